/* hw/rtl/lurt_pkg.sv */
// ----------------------------------------------------------------------------
// lurt_pkg
// Shared constants and types for the longest unique run tracker.
// ----------------------------------------------------------------------------
package lurt_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned AlphaSize = 256;
  localparam int unsigned AddrW     = $clog2(AlphaSize);

  typedef logic [LenW-1:0]  len_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CharW-1:0] char_t;

  // positions saturate here; a saturated byte is handled at MaxPos
  localparam len_t MaxStringLen = len_t'(65535);
  localparam len_t MaxPos       = MaxStringLen - len_t'(1);

  // control of the item sitting in the update stage
  typedef struct packed {
    logic  valid;
    logic  fwd;     // previous update wrote the same table entry
    addr_t idx;
    logic  eos;
  } s1_ctrl_t;

  typedef struct packed {
    len_t window_len;
    len_t best_len;
    logic final_result;
    logic overflow;
  } out_item_t;

endpackage

/* hw/rtl/lurt_intf.sv */
// ----------------------------------------------------------------------------
// lurt_in_if / lurt_out_if
// Valid/ready channels for input bytes and run-length results.
// ----------------------------------------------------------------------------
interface lurt_in_if;
  import lurt_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface lurt_out_if;
  import lurt_pkg::*;

  logic valid;
  logic ready;
  len_t window_len;
  len_t best_len;
  logic final_result;
  logic overflow;

  modport source (output valid, output window_len, output best_len,
                  output final_result, output overflow, input ready);
  modport sink   (input valid, input window_len, input best_len,
                  input final_result, input overflow, output ready);
endinterface

/* hw/rtl/lurt_ram.sv */
// ----------------------------------------------------------------------------
// lurt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lurt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/lurt_scan.sv */
// ----------------------------------------------------------------------------
// lurt_scan
// Update stage: window start, position, best length, valid bits.
// ----------------------------------------------------------------------------
module lurt_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lurt_pkg::s1_ctrl_t  ctrl_i,
  input  logic                fire_i,
  input  lurt_pkg::len_t      last_pos_i,
  output lurt_pkg::len_t      wr_pos_o,
  output lurt_pkg::out_item_t res_o
);
  import lurt_pkg::*;

  logic [AlphaSize-1:0] seen_q, seen_d;
  len_t                 ws_q, ws_d;
  len_t                 pos_cnt_q, pos_cnt_d;
  len_t                 best_q, best_d;
  logic                 ovf_q, ovf_d;
  len_t                 fwd_pos_q;

  logic                 sat;
  len_t                 pos;
  len_t                 last_pos;
  logic                 hit;
  logic [LenW:0]        next_start;
  len_t                 start_clamp;
  len_t                 start_hit;
  len_t                 start_new;
  len_t                 len;
  len_t                 best_new;
  logic                 ovf_new;

  always_comb begin
    sat         = (pos_cnt_q == MaxStringLen);
    pos         = sat ? MaxPos : pos_cnt_q;
    last_pos    = ctrl_i.fwd ? fwd_pos_q : last_pos_i;
    hit         = seen_q[ctrl_i.idx] && (last_pos >= ws_q);
    next_start  = {1'b0, last_pos} + {{LenW{1'b0}}, 1'b1};
    start_clamp = (next_start > {1'b0, pos}) ? pos : next_start[LenW-1:0];
    start_hit   = hit ? start_clamp : ws_q;
    start_new   = (start_hit > pos) ? pos : start_hit;
    len         = pos - start_new + len_t'(1);
    best_new    = (len > best_q) ? len : best_q;
    ovf_new     = ovf_q | sat;

    seen_d    = seen_q;
    ws_d      = ws_q;
    pos_cnt_d = pos_cnt_q;
    best_d    = best_q;
    ovf_d     = ovf_q;
    if (fire_i) begin
      if (ctrl_i.eos) begin
        seen_d    = '0;
        ws_d      = '0;
        pos_cnt_d = '0;
        best_d    = '0;
        ovf_d     = 1'b0;
      end else begin
        seen_d    = seen_q | ({{(AlphaSize-1){1'b0}}, 1'b1} << ctrl_i.idx);
        ws_d      = start_new;
        pos_cnt_d = sat ? pos_cnt_q : pos_cnt_q + len_t'(1);
        best_d    = best_new;
        ovf_d     = ovf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      ws_q      <= '0;
      pos_cnt_q <= '0;
      best_q    <= '0;
      ovf_q     <= 1'b0;
    end else begin
      seen_q    <= seen_d;
      ws_q      <= ws_d;
      pos_cnt_q <= pos_cnt_d;
      best_q    <= best_d;
      ovf_q     <= ovf_d;
    end
  end

  // copy of the last table write, for back-to-back hits on one entry
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      fwd_pos_q <= pos;
    end
  end

  assign wr_pos_o           = pos;
  assign res_o.window_len   = len;
  assign res_o.best_len     = best_new;
  assign res_o.final_result = ctrl_i.eos;
  assign res_o.overflow     = ovf_new;

endmodule

/* hw/rtl/longest_unique_run_tracker.sv */
// A result passes stage 1 and the output register before it is offered.
// Throughput: one byte per cycle while the result channel is not stalled,
//   set by the read-modify-write of the last-position table (read issued at
//   transfer, written when stage 1 fires, same-entry hits forwarded).
// Reset: clears all control and valid bits at once; no clearing pass, the
//   block takes bytes as soon as reset is released.
// ----------------------------------------------------------------------------
// longest_unique_run_tracker
// Streams a string a byte at a time and reports the current and longest
// repeat-free run lengths for every byte.
// ----------------------------------------------------------------------------
module longest_unique_run_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  lurt_in_if.sink    in_i,
  lurt_out_if.source out_o
);
  import lurt_pkg::*;

  // Stage 0: input transfer launches the table read.
  // Stage 1: table data back, window and best length updated, table written.
  // Output register decouples stage 1 from a stalled consumer.

  s1_ctrl_t  s1_q, s1_d;
  logic      in_xfer;
  logic      s1_fire;
  addr_t     in_idx;

  len_t      last_pos;
  len_t      wr_pos;
  out_item_t res;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  // char codes index the alphabet directly; AddrW equals CharW, so all bits are kept
  assign in_idx   = addr_t'(in_i.char_code);

  assign s1_fire  = s1_q.valid && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_q.valid || s1_fire;
  assign in_xfer  = in_i.valid && in_i.ready;

  always_comb begin
    s1_d = s1_q;
    if (in_xfer) begin
      s1_d.valid = 1'b1;
      s1_d.idx   = in_idx;
      s1_d.eos   = in_i.end_of_string;
      // RAM returns stale data when the entry is written in the read cycle
      s1_d.fwd   = s1_fire && (in_idx == s1_q.idx);
    end else if (s1_fire) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  // last position per byte value; read data holds while stage 1 stalls
  lurt_ram #(
    .Width (LenW),
    .Depth (AlphaSize)
  ) u_last_pos (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_q.idx),
    .wdata_i (wr_pos),
    .re_i    (in_xfer),
    .raddr_i (in_idx),
    .rdata_o (last_pos)
  );

  lurt_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (s1_q),
    .fire_i     (s1_fire),
    .last_pos_i (last_pos),
    .wr_pos_o   (wr_pos),
    .res_o      (res)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.window_len   = out_q.window_len;
  assign out_o.best_len     = out_q.best_len;
  assign out_o.final_result = out_q.final_result;
  assign out_o.overflow     = out_q.overflow;

endmodule

/* hw/rtl/lurt_checker.sv */
// ----------------------------------------------------------------------------
// lurt_port_checks
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lurt_port_checks (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input lurt_pkg::len_t window_len_i,
  input lurt_pkg::len_t best_len_i,
  input logic           final_result_i,
  input logic           overflow_i
);
  import lurt_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(window_len_i) && $stable(best_len_i) &&
      $stable(final_result_i) && $stable(overflow_i))
    else $error("result changed while stalled");

  // every window holds at least the current byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> window_len_i != len_t'(0))
    else $error("empty window reported");

  // best length never trails the current window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> best_len_i >= window_len_i)
    else $error("best length below window length");

endmodule

bind longest_unique_run_tracker lurt_port_checks u_port_checks (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .window_len_i   (out_o.window_len),
  .best_len_i     (out_o.best_len),
  .final_result_i (out_o.final_result),
  .overflow_i     (out_o.overflow)
);
